// ===== rtl/core/tsr_pkg.sv =====
// Shared types and codes for the timed step ramp evaluator.
// No dependencies; imported by every module of the block except tsr_div.
`default_nettype none

package tsr_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_TIME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BEFORE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_AFTER = 3'd4;

	// Blend curve selector. The unused fourth code behaves as the quintic curve.
	localparam logic [1:0] CURVE_LINEAR   = 2'd0;
	localparam logic [1:0] CURVE_SMOOTH   = 2'd1;
	localparam logic [1:0] CURVE_SMOOTHER = 2'd2;

	// Operation select.
	localparam logic OP_VALUE = 1'b0;
	localparam logic OP_DERIV = 1'b1;

	// Where the sample lies relative to the transition.
	localparam logic [1:0] REGION_BEFORE = 2'd0;
	localparam logic [1:0] REGION_AFTER  = 2'd1;
	localparam logic [1:0] REGION_INSIDE = 2'd2;

	typedef struct packed {
		logic       op;
		logic [1:0] region;
	} tsr_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsr_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used twice by the timed step ramp evaluator.
`default_nettype none

module tsr_div #(
	parameter int QBITS = 16,
	parameter int DEN_W = 33,
	parameter int SB_W  = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] in_rem,
	input  logic [QBITS-1:0] in_low,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [QBITS-1:0] out_quo,
	output logic [SB_W-1:0]  out_sb
);

	// The partial remainder must start below the divisor; the quotient then fits QBITS.
	logic             valid_s [QBITS];
	logic [DEN_W-1:0] rem_s   [QBITS];
	logic [QBITS-1:0] low_s   [QBITS];
	logic [QBITS-1:0] quo_s   [QBITS];
	logic [SB_W-1:0]  sb_s    [QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic             pv;
		logic [DEN_W-1:0] prem;
		logic [QBITS-1:0] plow;
		logic [QBITS-1:0] pquo;
		logic [SB_W-1:0]  psb;
		logic [DEN_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = in_rem;
			assign plow = in_low;
			assign pquo = '0;
			assign psb  = in_sb;
		end else begin : g_next
			assign pv   = valid_s[k-1];
			assign prem = rem_s[k-1];
			assign plow = low_s[k-1];
			assign pquo = quo_s[k-1];
			assign psb  = sb_s[k-1];
		end

		assign trial = {prem, plow[QBITS-1]};
		assign take  = (trial >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			low_s[k] <= plow << 1;
			quo_s[k] <= {pquo[QBITS-2:0], take};
			sb_s[k]  <= psb;
		end
	end

	assign out_valid = valid_s[QBITS-1];
	assign out_quo   = quo_s[QBITS-1];
	assign out_sb    = sb_s[QBITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/tsr_shape.sv =====
// Five-stage polynomial datapath: shaped fraction and slope from the Q0.F fraction.
// Depends on tsr_pkg for the curve codes and the item tag.
`default_nettype none

module tsr_shape #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [FRAC_BITS-1:0]   frac,
	input  logic [1:0]             curve,
	input  tsr_pkg::tsr_tag_t      in_tag,
	output logic                   out_valid,
	output logic [FRAC_BITS-1:0]   shape_p,
	output logic [FRAC_BITS+1:0]   slope_g,
	output tsr_pkg::tsr_tag_t      out_tag
);
	import tsr_pkg::*;

	localparam int FB = FRAC_BITS;
	localparam int QSW = 2 * FB + 6;
	localparam logic [FB:0]   ONE_FX      = (FB + 1)'(1) << FB;
	localparam logic [FB+1:0] ONE_G       = (FB + 2)'(1) << FB;
	localparam logic [FB+1:0] THREE_ONE   = (FB + 2)'(3) << FB;
	localparam logic [FB+4:0] FIFTEEN_ONE = (FB + 5)'(15) << FB;
	localparam logic signed [QSW-1:0] QS_TEN = QSW'(10) << (2 * FB);

	logic     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	tsr_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [FB-1:0]         f_s1, f_s2, f_s3, f_s4;
	logic [2*FB-1:0]       sq_s1;
	logic [FB:0]           om_s1;
	logic [FB+1:0]         m1_s1;
	logic signed [FB+4:0]  inner_s1;

	logic [3*FB+1:0]       s3_s2;
	logic [3*FB-1:0]       cube_s2;
	logic signed [QSW-1:0] qs_s2;
	logic [2*FB:0]         h_s2;

	logic [FB-1:0]         p_sm_s3, p_sm_s4;
	logic [2*FB-1:0]       c_s3;
	logic [FB+3:0]         q_s3;
	logic [2*FB-1:0]       hh_s3;
	logic [FB+1:0]         g_sm_s3, g_sm_s4;

	logic [FB-1:0]         p_q_s4;
	logic [FB+1:0]         g_q_s4;

	logic [FB-1:0]         p_s5;
	logic [FB+1:0]         g_s5;

	logic [4*FB+1:0]       hsq;
	logic [2*FB+3:0]       h6;
	logic [3*FB+3:0]       pq;
	logic [2*FB+4:0]       g30;

	always_comb begin
		hsq = h_s2 * h_s2;
		h6  = h_s2 * (2 * FB + 4)'(6);
		pq  = c_s3 * q_s3;
		g30 = hh_s3 * (2 * FB + 5)'(30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// Square and the linear factors of both polynomials.
		tag_s1   <= in_tag;
		f_s1     <= frac;
		sq_s1    <= frac * frac;
		om_s1    <= ONE_FX - {1'b0, frac};
		m1_s1    <= THREE_ONE - (FB + 2)'({frac, 1'b0});
		inner_s1 <= (FB + 5)'(frac) * (FB + 5)'(6) - FIFTEEN_ONE;

		// One multiplication for each of the partial terms.
		tag_s2  <= tag_s1;
		f_s2    <= f_s1;
		s3_s2   <= sq_s1 * m1_s1;
		cube_s2 <= sq_s1 * f_s1;
		qs_s2   <= $signed({1'b0, f_s1}) * inner_s1 + QS_TEN;
		h_s2    <= f_s1 * om_s1;

		tag_s3  <= tag_s2;
		f_s3    <= f_s2;
		p_sm_s3 <= s3_s2[3*FB-1:2*FB];
		c_s3    <= cube_s2[3*FB-1:FB];
		q_s3    <= qs_s2[2*FB+3:FB];
		hh_s3   <= hsq[4*FB-1:2*FB];
		g_sm_s3 <= h6[2*FB+1:FB];

		tag_s4  <= tag_s3;
		f_s4    <= f_s3;
		p_sm_s4 <= p_sm_s3;
		g_sm_s4 <= g_sm_s3;
		p_q_s4  <= pq[3*FB-1:2*FB];
		g_q_s4  <= g30[2*FB+1:FB];

		tag_s5 <= tag_s4;
		case (curve)
			CURVE_LINEAR: begin
				p_s5 <= f_s4;
				g_s5 <= ONE_G;
			end
			CURVE_SMOOTH: begin
				p_s5 <= p_sm_s4;
				g_s5 <= g_sm_s4;
			end
			default: begin
				p_s5 <= p_q_s4;
				g_s5 <= g_q_s4;
			end
		endcase
	end

	assign out_valid = valid_s5;
	assign shape_p   = p_s5;
	assign slope_g   = g_s5;
	assign out_tag   = tag_s5;

endmodule

`default_nettype wire

// ===== rtl/core/timed_step_ramp_evaluator.sv =====
// Timed step ramp evaluator: a fully pipelined value and slope unit for a timed transition.
// Pipeline: stage 1, the fraction divider, the curve datapath, stages 2 to 4, the slope divider
// and the output register; the two bit-per-stage dividers make up most of its depth.
// Throughput: one sample per clock, every clock; busy is always low.
// Reset: arst_n clears all valid bits and loads the configuration register defaults.
// Depends on tsr_pkg, tsr_div and tsr_shape.
`default_nettype none

module timed_step_ramp_evaluator #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [DATA_WIDTH-1:0]           cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic signed [DATA_WIDTH-1:0]    sample_time,
	output logic                            done,
	output logic signed [DATA_WIDTH-1:0]    result_value,
	output logic                            saturated
);
	import tsr_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int PVW  = DW + FB + 2;
	localparam int NW   = DW + FB + 4;
	localparam int TAGW = $bits(tsr_tag_t);
	localparam int SB2W = TAGW + DW + 2;
	localparam logic [DW-1:0] HALF_RANGE = DW'(1) << (DW - 1);

	// Configuration registers. The user must change them only while the pipeline is empty, so every
	// stage reads them directly, not a copy per sample; the block does not enforce this.
	logic [1:0]           curve_q;
	logic signed [DW-1:0] start_time_q;
	logic signed [DW-1:0] end_time_q;
	logic signed [DW-1:0] level_before_q;
	logic signed [DW-1:0] level_after_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q        <= CURVE_SMOOTHER;
			start_time_q   <= '0;
			end_time_q     <= DW'(1) << FB;
			level_before_q <= '0;
			level_after_q  <= DW'(1) << FB;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CURVE:        curve_q        <= cfg_data[1:0];
				CFG_START_TIME:   start_time_q   <= cfg_data;
				CFG_END_TIME:     end_time_q     <= cfg_data;
				CFG_LEVEL_BEFORE: level_before_q <= cfg_data;
				CFG_LEVEL_AFTER:  level_after_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Ramp duration and level step, one bit wider than the data so neither can wrap.
	// The duration is only used for samples inside the ramp, where it is positive.
	logic signed [DW:0] dur_w;
	logic signed [DW:0] diff_w;
	logic [DW:0]        den_w;

	assign dur_w  = {end_time_q[DW-1], end_time_q} - {start_time_q[DW-1], start_time_q};
	assign diff_w = {level_after_q[DW-1], level_after_q}
		- {level_before_q[DW-1], level_before_q};
	assign den_w  = dur_w;

	// Stage 1: classify the sample and form the offset into the ramp.
	logic       region_w;
	logic [1:0] region_code;
	logic       valid_s1;
	tsr_tag_t   tag_s1;
	logic [DW:0] num_s1;

	assign region_w = (sample_time < start_time_q);

	always_comb begin
		if (region_w) begin
			region_code = REGION_BEFORE;
		end else if (sample_time >= end_time_q) begin
			region_code = REGION_AFTER;
		end else begin
			region_code = REGION_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.op     <= operation;
		tag_s1.region <= region_code;
		num_s1        <= {sample_time[DW-1], sample_time} - {start_time_q[DW-1], start_time_q};
	end

	// Fraction divider: the offset is below the duration, so FRAC_BITS stages give the
	// truncated Q0.F fraction directly.
	logic          frac_valid;
	logic [FB-1:0] frac_quo;
	tsr_tag_t      frac_tag;

	tsr_div #(
		.QBITS (FB),
		.DEN_W (DW + 1),
		.SB_W  (TAGW)
	) u_frac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_rem    (num_s1),
		.in_low    ('0),
		.den       (den_w),
		.in_sb     (tag_s1),
		.out_valid (frac_valid),
		.out_quo   (frac_quo),
		.out_sb    (frac_tag)
	);

	// Curve evaluation.
	logic          shp_valid;
	logic [FB-1:0] shp_p;
	logic [FB+1:0] shp_g;
	tsr_tag_t      shp_tag;

	tsr_shape #(
		.FRAC_BITS (FB)
	) u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frac_valid),
		.frac      (frac_quo),
		.curve     (curve_q),
		.in_tag    (frac_tag),
		.out_valid (shp_valid),
		.shape_p   (shp_p),
		.slope_g   (shp_g),
		.out_tag   (shp_tag)
	);

	// Stage 2: scale both the shaped fraction and the slope by the level step.
	logic                  valid_s2;
	tsr_tag_t              tag_s2;
	logic signed [PVW-1:0] pv_s2;
	logic signed [NW-1:0]  pd_s2;

	// Stage 3: finish the value and take the magnitude of the slope numerator.
	logic                  valid_s3;
	tsr_tag_t              tag_s3;
	logic [DW-1:0]         val_s3;
	logic                  neg_s3;
	logic [NW-1:0]         mag_s3;

	// Stage 4: detect a quotient too large for the data width, split the dividend.
	logic                  valid_s4;
	tsr_tag_t              tag_s4;
	logic [DW-1:0]         val_s4;
	logic                  neg_s4;
	logic                  ovf_s4;
	logic [DW:0]           rem0_s4;
	logic [DW-1:0]         low_s4;

	logic signed [PVW-1:0] pv_sh;
	logic [NW-1:0]         pd_u;
	logic [NW-1:0]         mag_hi;

	assign pv_sh  = pv_s2 >>> FB;
	assign pd_u   = pd_s2;
	assign mag_hi = mag_s3 >> DW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= shp_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= shp_tag;
		pv_s2  <= diff_w * $signed({1'b0, shp_p});
		pd_s2  <= diff_w * $signed({1'b0, shp_g});

		// The value path resolves here; outside the ramp the slope is zero.
		tag_s3 <= tag_s2;
		if (tag_s2.op == OP_DERIV && tag_s2.region != REGION_INSIDE) begin
			val_s3 <= '0;
		end else if (tag_s2.region == REGION_BEFORE) begin
			val_s3 <= level_before_q;
		end else if (tag_s2.region == REGION_AFTER) begin
			val_s3 <= level_after_q;
		end else begin
			val_s3 <= level_before_q + pv_sh[DW-1:0];
		end
		neg_s3 <= pd_s2[NW-1];
		mag_s3 <= pd_s2[NW-1] ? (~pd_u + NW'(1)) : pd_u;

		tag_s4  <= tag_s3;
		val_s4  <= val_s3;
		neg_s4  <= neg_s3;
		ovf_s4  <= (mag_hi >= NW'(den_w));
		rem0_s4 <= mag_hi[DW:0];
		low_s4  <= mag_s3[DW-1:0];
	end

	// Slope divider: truncating division of the magnitude, DATA_WIDTH quotient bits.
	// Larger quotients were flagged in stage 4 and saturate regardless of these bits.
	logic            sl_valid;
	logic [DW-1:0]   sl_quo;
	logic [SB2W-1:0] sl_sb;
	tsr_tag_t        sl_tag;
	logic [DW-1:0]   sl_val;
	logic            sl_neg;
	logic            sl_ovf;

	tsr_div #(
		.QBITS (DW),
		.DEN_W (DW + 1),
		.SB_W  (SB2W)
	) u_slope_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_rem    (rem0_s4),
		.in_low    (low_s4),
		.den       (den_w),
		.in_sb     ({tag_s4, val_s4, neg_s4, ovf_s4}),
		.out_valid (sl_valid),
		.out_quo   (sl_quo),
		.out_sb    (sl_sb)
	);

	assign sl_tag = sl_sb[SB2W-1 -: TAGW];
	assign sl_val = sl_sb[DW+1:2];
	assign sl_neg = sl_sb[1];
	assign sl_ovf = sl_sb[0];

	// Output register: apply the sign and clip the slope to the signed data range.
	// A negative quotient may reach exactly half the range without clipping.
	logic          slope_item;
	logic          clip_w;
	logic [DW-1:0] slope_w;
	logic          done_q;
	logic          sat_q;
	logic [DW-1:0] result_q;

	assign slope_item = (sl_tag.op == OP_DERIV) && (sl_tag.region == REGION_INSIDE);

	always_comb begin
		if (sl_neg) begin
			clip_w  = sl_ovf || (sl_quo > HALF_RANGE);
			slope_w = clip_w ? HALF_RANGE : (~sl_quo + DW'(1));
		end else begin
			clip_w  = sl_ovf || sl_quo[DW-1];
			slope_w = clip_w ? ~HALF_RANGE : sl_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else begin
			done_q <= sl_valid;
			sat_q  <= sl_valid && slope_item && clip_w;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= slope_item ? slope_w : sl_val;
	end

	assign done         = done_q;
	assign saturated    = sat_q;
	assign result_value = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/tsr_chk.sv =====
// Port-level checker for the timed step ramp evaluator and the bind that attaches it.
// Depends on tsr_pkg for the configuration index width.
`default_nettype none

module tsr_chk #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [DATA_WIDTH-1:0]         cfg_data,
	input logic                          start,
	input logic                          busy,
	input logic                          operation,
	input logic [DATA_WIDTH-1:0]         sample_time,
	input logic                          done,
	input logic [DATA_WIDTH-1:0]         result_value,
	input logic                          saturated
);
	import tsr_pkg::*;

	localparam int LAT = DATA_WIDTH + FRAC_BITS + 10;
	localparam logic [DATA_WIDTH-1:0] MIN_VAL = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

	// Every start transfer produces exactly one strobe, and no strobe comes without one.
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after a start transfer");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching start transfer");

	a_sat_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		saturated |-> done)
		else $error("saturation flag outside a result transfer");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (result_value == MIN_VAL || result_value == ~MIN_VAL))
		else $error("clipped slope is not at a range limit");

	// A transfer on either input channel carries fully known data.
	a_known_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		((start && !busy) |-> !$isunknown({operation, sample_time}))
		and ((cfg_valid && cfg_ready) |-> !$isunknown({cfg_index, cfg_data})))
		else $error("unknown bits in an input transfer");

endmodule

bind timed_step_ramp_evaluator tsr_chk #(
	.DATA_WIDTH (DATA_WIDTH),
	.FRAC_BITS  (FRAC_BITS)
) u_tsr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.sample_time  (sample_time),
	.done         (done),
	.result_value (result_value),
	.saturated    (saturated)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the timed step ramp evaluator: a per-sample predictor
// of the value and slope arithmetic checks every strobed result in order.
// Depends on tsr_pkg and timed_step_ramp_evaluator.
`timescale 1ns / 100ps

module testbench;
	import tsr_pkg::*;

	localparam int LATENCY = 57;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic operation = 1'b0;
	logic signed [31:0] sample_time = '0;
	logic done;
	logic signed [31:0] result_value;
	logic saturated;

	timed_step_ramp_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.operation(operation), .sample_time(sample_time),
		.done(done), .result_value(result_value), .saturated(saturated)
	);

	// The clock runs at 100 MHz.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic signed [31:0] level;
		logic               clipped;
	} ramp_result_t;

	// The bench keeps its own copy of the five configuration registers.
	logic [1:0] shadow_curve;
	longint shadow_start, shadow_end, shadow_before, shadow_after;

	ramp_result_t pending_results[$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	int sender_idle_pct = 0;
	longint cycles = 0;

	// Rounds towards minus infinity, as an arithmetic shift of a signed value does.
	function automatic longint floor_shr(longint x, int n);
		return x >>> n;
	endfunction

	// Works out the level or slope the block must give for one sample.
	function automatic ramp_result_t predict_ramp(logic op, logic signed [31:0] t_in);
		ramp_result_t r;
		longint t, dur, num, diff, slope, lim_hi, lim_lo, lvl;
		longint unsigned frac, shape, q, cube, h, g;
		t = t_in;
		r.clipped = 1'b0;
		lim_hi = 64'sd2147483647;
		lim_lo = -64'sd2147483648;
		if (t < shadow_start) begin
			r.level = (op == OP_DERIV) ? 32'sd0 : shadow_before[31:0];
		end else if (t >= shadow_end) begin
			r.level = (op == OP_DERIV) ? 32'sd0 : shadow_after[31:0];
		end else begin
			dur = shadow_end - shadow_start;
			num = t - shadow_start;
			frac = longint'(num << 16) / dur;
			diff = shadow_after - shadow_before;
			if (op == OP_VALUE) begin
				if (shadow_curve == CURVE_LINEAR) begin
					shape = frac;
				end else if (shadow_curve == CURVE_SMOOTH) begin
					shape = (frac * frac * (3 * 65536 - 2 * frac)) >> 32;
				end else begin
					// Quintic: the product is split so that no term exceeds 64 bits.
					q = longint'(longint'(frac) * (6 * longint'(frac) - 15 * 65536)
						+ 10 * (64'sd1 << 32)) >> 16;
					cube = (frac * frac * frac) >> 16;
					shape = (cube * q) >> 32;
				end
				lvl = shadow_before + floor_shr(diff * longint'(shape), 16);
				r.level = lvl[31:0];
			end else begin
				if (shadow_curve == CURVE_LINEAR) begin
					g = 65536;
				end else if (shadow_curve == CURVE_SMOOTH) begin
					g = (6 * frac * (65536 - frac)) >> 16;
				end else begin
					h = frac * (65536 - frac);
					g = (30 * ((h * h) >> 32)) >> 16;
				end
				// Signed division in SystemVerilog truncates towards zero.
				slope = (diff * longint'(g)) / dur;
				if (slope > lim_hi) begin
					slope = lim_hi;
					r.clipped = 1'b1;
				end else if (slope < lim_lo) begin
					slope = lim_lo;
					r.clipped = 1'b1;
				end
				r.level = slope[31:0];
			end
		end
		return r;
	endfunction

	// Every strobe is a transfer; it is compared with the oldest expectation.
	always @(posedge clk) begin
		ramp_result_t want;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: value %0d", result_value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (result_value !== want.level) begin
					$error("result_value: expected %0d, got %0d", want.level, result_value);
					errors++;
				end
				if (saturated !== want.clipped) begin
					$error("saturated: expected %0b, got %0b", want.clipped, saturated);
					errors++;
				end
			end
		end
	end

	// A run that stalls or drops results is stopped here.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timed_step_ramp_evaluator: mismatch");
			$finish;
		end
	end

	// Sends one sample; the transfer happens at the edge where start is high and busy low.
	// start stays high afterwards so that samples can follow back to back.
	task automatic send_sample(logic op, logic signed [31:0] t);
		while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		sample_time <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_ramp(op, t));
		sent++;
	endtask

	// Waits for every expectation, then lets the pipeline empty before a register write.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CURVE:        shadow_curve = val[1:0];
			CFG_START_TIME:   shadow_start = longint'(signed'(val));
			CFG_END_TIME:     shadow_end = longint'(signed'(val));
			CFG_LEVEL_BEFORE: shadow_before = longint'(signed'(val));
			CFG_LEVEL_AFTER:  shadow_after = longint'(signed'(val));
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_ramp(logic [1:0] curve, logic [31:0] t0, logic [31:0] t1,
			logic [31:0] lv0, logic [31:0] lv1);
		drain_pipeline();
		write_register(CFG_CURVE, {30'd0, curve});
		write_register(CFG_START_TIME, t0);
		write_register(CFG_END_TIME, t1);
		write_register(CFG_LEVEL_BEFORE, lv0);
		write_register(CFG_LEVEL_AFTER, lv1);
	endtask

	// Samples that sit at the edges of the ramp and at the extremes of time.
	task automatic test_directed_edges();
		logic signed [31:0] s, e;
		s = shadow_start[31:0];
		e = shadow_end[31:0];
		send_sample(OP_VALUE, 32'sh80000000);
		send_sample(OP_VALUE, 32'sh7fffffff);
		send_sample(OP_DERIV, 32'sh80000000);
		send_sample(OP_DERIV, 32'sh7fffffff);
		send_sample(OP_VALUE, s - 1);
		send_sample(OP_VALUE, s);
		send_sample(OP_DERIV, s);
		send_sample(OP_VALUE, e - 1);
		send_sample(OP_DERIV, e - 1);
		send_sample(OP_VALUE, e);
		send_sample(OP_DERIV, e);
		send_sample(OP_VALUE, s + (e - s) / 2);
		send_sample(OP_DERIV, s + (e - s) / 2);
	endtask

	// Reset values, every curve, a steep clipped slope, an empty ramp and unused register indexes.
	task automatic test_directed();
		test_directed_edges();
		set_ramp(CURVE_LINEAR, 32'h0, 32'h1, 32'h80000000, 32'h7fffffff);
		test_directed_edges();
		set_ramp(CURVE_SMOOTH, 32'hffff0000, 32'h00030000, 32'h7fffffff, 32'h80000000);
		test_directed_edges();
		set_ramp(2'd3, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		test_directed_edges();
		// An end time that does not follow the start leaves no interior.
		set_ramp(CURVE_SMOOTHER, 32'h00050000, 32'h00050000, 32'h1234, 32'h5678);
		send_sample(OP_VALUE, 32'h0004ffff);
		send_sample(OP_VALUE, 32'h00050000);
		set_ramp(CURVE_SMOOTH, 32'h00050000, 32'hfff00000, 32'h1234, 32'h5678);
		send_sample(OP_DERIV, 32'h00000000);
		send_sample(OP_VALUE, 32'h00050000);
		// An out-of-range register index must change nothing.
		drain_pipeline();
		write_register(3'd7, 32'hdeadbeef);
		write_register(3'd5, 32'h0);
		send_sample(OP_VALUE, 32'h00050001);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3, 0))
			0: return $urandom;
			1: return $urandom_range(65535, 0) << $urandom_range(16, 0);
			2: return -($urandom_range(65535, 0) << $urandom_range(16, 0));
			default: return $urandom_range(1, 0) ? (32'h80000000 | 32'($urandom_range(7, 0)))
				: (32'h7fffffff ^ 32'($urandom_range(7, 0)));
		endcase
	endfunction

	// Random ramps; most samples fall inside the interval so the blends are exercised.
	task automatic test_random(int phases, int per_phase);
		logic signed [31:0] t0, t1, t;
		longint span;
		for (int p = 0; p < phases; p++) begin
			t0 = rand_word();
			t1 = ($urandom_range(9, 0) == 0) ? rand_word()
				: t0 + ($urandom_range(1, 0) ? $urandom_range(200, 1) : ($urandom >> $urandom_range(31, 1)));
			if ($urandom_range(5, 0) == 0) t1 = 32'sh7fffffff;
			set_ramp(2'($urandom_range(3, 0)), t0, t1, rand_word(), rand_word());
			span = longint'(shadow_end) - longint'(shadow_start);
			for (int k = 0; k < per_phase; k++) begin
				if (span > 0 && $urandom_range(9, 0) < 8)
					t = 32'(shadow_start + longint'({$urandom, $urandom} % span));
				else
					t = rand_word();
				send_sample(1'($urandom_range(1, 0)), t);
			end
		end
	endtask

	initial begin
		shadow_curve = CURVE_SMOOTHER;
		shadow_start = 0;
		shadow_end = 65536;
		shadow_before = 0;
		shadow_after = 65536;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		sender_idle_pct = 27;
		test_random(25, 20);
		sender_idle_pct = 49;
		test_random(25, 20);
		sender_idle_pct = 0;
		test_random(25, 20);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d samples over many ramp settings and all curves; %0d results checked.",
			sent, checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("timed_step_ramp_evaluator: match");
		else
			$display("timed_step_ramp_evaluator: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/tsr_pkg.sv
rtl/core/tsr_div.sv
rtl/core/tsr_shape.sv
rtl/core/timed_step_ramp_evaluator.sv
rtl/core/tsr_chk.sv
bench/testbench.sv
